@@ hw/rtl/bwat_pkg.sv @@
`default_nettype none

package bwat_pkg;

	localparam int NOW_W      = 23;
	localparam int ACT_W      = 16;
	localparam int LEN_W      = 16;
	localparam int CNT_REG_W  = 7;
	localparam int TOT_W      = 23;
	localparam int OUT_W      = 22;
	localparam int DIV_STEPS  = 23;
	localparam int DIVCNT_W   = 5;
	localparam int APB_DW     = 32;
	localparam int APB_AW     = 3;

	localparam logic [LEN_W-1:0]     LEN_RESET   = 16'd60;
	localparam logic [CNT_REG_W-1:0] COUNT_RESET = 7'd60;

	// register select taken from the word address bit
	localparam logic REG_LENGTH = 1'b0;
	localparam logic REG_COUNT  = 1'b1;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_CFG_CLR,
		OP_CLR_STEP,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_FULL,
		OP_SCAN_INIT,
		OP_SCAN_RD,
		OP_SCAN_WR,
		OP_ADD_RD,
		OP_ADD_WR,
		OP_OUT
	} op_t;

	typedef struct packed {
		logic need_adv;
		logic div_done;
		logic full_adv;
		logic scan_last;
		logic clr_last;
		logic act_pos;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/bwat_ctrl.sv @@
`default_nettype none

module bwat_ctrl
	import bwat_pkg::*;
(
	input  wire  clk,
	input  wire  arst_n,
	input  wire  in_valid,
	input  wire  cfg_clear,
	input  sts_t sts,
	output op_t  cmd,
	output logic in_stall
);

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_CHECK,
		S_DIV,
		S_DECIDE,
		S_SCAN_RD,
		S_SCAN_WR,
		S_ADD,
		S_ADD_WR,
		S_DONE
	} state_t;

	state_t state_q, state_d;
	logic   ret_add_q, ret_add_d;

	always_comb begin
		state_d   = state_q;
		ret_add_d = ret_add_q;
		cmd       = OP_NONE;
		unique case (state_q)
			S_CLEAR: begin
				if (cfg_clear && !ret_add_q) begin
					// restart the sweep from the bottom
					cmd = OP_CFG_CLR;
				end else begin
					cmd = OP_CLR_STEP;
					if (sts.clr_last) begin
						state_d = ret_add_q ? S_ADD : S_IDLE;
					end
				end
			end
			S_IDLE: begin
				if (cfg_clear) begin
					cmd       = OP_CFG_CLR;
					ret_add_d = 1'b0;
					state_d   = S_CLEAR;
				end else if (in_valid) begin
					cmd     = OP_LOAD;
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (sts.need_adv) begin
					cmd     = OP_DIV_INIT;
					state_d = S_DIV;
				end else begin
					state_d = S_ADD;
				end
			end
			S_DIV: begin
				if (sts.div_done) begin
					state_d = S_DECIDE;
				end else begin
					cmd = OP_DIV_STEP;
				end
			end
			S_DECIDE: begin
				if (sts.full_adv) begin
					cmd       = OP_FULL;
					ret_add_d = 1'b1;
					state_d   = S_CLEAR;
				end else begin
					cmd     = OP_SCAN_INIT;
					state_d = S_SCAN_RD;
				end
			end
			S_SCAN_RD: begin
				cmd     = OP_SCAN_RD;
				state_d = S_SCAN_WR;
			end
			S_SCAN_WR: begin
				cmd     = OP_SCAN_WR;
				state_d = sts.scan_last ? S_ADD : S_SCAN_RD;
			end
			S_ADD: begin
				if (sts.act_pos) begin
					cmd     = OP_ADD_RD;
					state_d = S_ADD_WR;
				end else begin
					state_d = S_DONE;
				end
			end
			S_ADD_WR: begin
				cmd     = OP_ADD_WR;
				state_d = S_DONE;
			end
			S_DONE: begin
				// hold until the output register can take the total
				if (sts.out_free) begin
					cmd     = OP_OUT;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign in_stall = (state_q != S_IDLE) || cfg_clear;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			ret_add_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			ret_add_q <= ret_add_d;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/bwat_datapath.sv @@
`default_nettype none

module bwat_datapath
	import bwat_pkg::*;
#(
	parameter int MAX_BUCKETS = 64
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  op_t                        cmd,
	output sts_t                       sts,
	input  wire  [LEN_W-1:0]           bucket_length,
	input  wire  [CNT_REG_W-1:0]       bucket_count,
	input  wire  [NOW_W-1:0]           now_seconds,
	input  wire  signed [ACT_W-1:0]    active_seconds,
	input  wire                        out_stall,
	output logic                       out_valid,
	output logic [OUT_W-1:0]           window_total
);

	localparam int IDX_W = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
	localparam int CNT_W = $clog2(MAX_BUCKETS + 1);
	localparam int CMP_W = (CNT_W > CNT_REG_W) ? CNT_W : CNT_REG_W;

	logic [LEN_W-1:0] mem [MAX_BUCKETS];

	logic [NOW_W-1:0]    now_q, start_q, quo_q;
	logic [ACT_W-1:0]    act_q;
	logic                started_q;
	logic [TOT_W-1:0]    total_q;
	logic [IDX_W-1:0]    cur_q, idx_q, clr_q;
	logic [CNT_W-1:0]    left_q;
	logic [LEN_W-1:0]    rem_q, rd_q;
	logic [DIVCNT_W-1:0] div_cnt_q;
	logic                out_valid_q;
	logic [OUT_W-1:0]    window_total_q;

	logic [LEN_W-1:0] len_eff;
	logic [CMP_W-1:0] count_ext;
	logic [CNT_W-1:0] n_eff;
	logic [NOW_W-1:0] elapsed;
	logic [CNT_W-1:0] cur_inc, idx_inc;
	logic [IDX_W-1:0] cur_next, idx_next;
	logic [LEN_W:0]   div_sh;
	logic             div_ge;
	logic [LEN_W:0]   add_sum;
	logic [LEN_W-1:0] add_next;

	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	logic [LEN_W-1:0] mem_wdata;

	always_comb begin
		len_eff   = (bucket_length == '0) ? LEN_W'(1) : bucket_length;
		count_ext = CMP_W'(bucket_count);
		if (count_ext == '0) begin
			n_eff = CNT_W'(1);
		end else if (count_ext > CMP_W'(MAX_BUCKETS)) begin
			n_eff = CNT_W'(MAX_BUCKETS);
		end else begin
			n_eff = CNT_W'(count_ext);
		end
	end

	assign elapsed  = now_q - start_q;
	assign cur_inc  = CNT_W'(cur_q) + CNT_W'(1);
	assign idx_inc  = CNT_W'(idx_q) + CNT_W'(1);
	assign cur_next = (cur_inc >= n_eff) ? '0 : IDX_W'(cur_inc);
	assign idx_next = (idx_inc >= n_eff) ? '0 : IDX_W'(idx_inc);

	// one restoring step of elapsed / bucket length
	assign div_sh = {rem_q, quo_q[NOW_W-1]};
	assign div_ge = div_sh >= {1'b0, len_eff};

	assign add_sum  = {1'b0, rd_q} + {2'b0, act_q[ACT_W-2:0]};
	assign add_next = (add_sum > {1'b0, len_eff}) ? len_eff : add_sum[LEN_W-1:0];

	always_comb begin
		sts.need_adv  = (now_q >= start_q) && (elapsed >= NOW_W'(len_eff));
		sts.div_done  = div_cnt_q == DIVCNT_W'(DIV_STEPS);
		sts.full_adv  = quo_q >= NOW_W'(n_eff);
		sts.scan_last = left_q == CNT_W'(1);
		sts.clr_last  = clr_q == IDX_W'(MAX_BUCKETS - 1);
		sts.act_pos   = !act_q[ACT_W-1] && (act_q != '0);
		sts.out_free  = !out_valid_q || !out_stall;
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cur_q;
		mem_wdata = '0;
		case (cmd)
			OP_CLR_STEP: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
			end
			OP_SCAN_WR: begin
				mem_we    = 1'b1;
				mem_waddr = idx_q;
			end
			OP_ADD_WR: begin
				mem_we    = 1'b1;
				mem_wdata = add_next;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (cmd == OP_SCAN_RD) begin
			rd_q <= mem[idx_q];
		end else if (cmd == OP_ADD_RD) begin
			rd_q <= mem[cur_q];
		end
	end

	always_ff @(posedge clk) begin
		case (cmd)
			OP_LOAD: begin
				now_q <= now_seconds;
				act_q <= active_seconds;
			end
			OP_DIV_INIT: begin
				quo_q <= elapsed;
				rem_q <= '0;
			end
			OP_DIV_STEP: begin
				rem_q <= div_ge ? LEN_W'(div_sh - {1'b0, len_eff}) : div_sh[LEN_W-1:0];
				quo_q <= {quo_q[NOW_W-2:0], div_ge};
			end
			OP_SCAN_INIT: begin
				idx_q  <= cur_next;
				left_q <= CNT_W'(quo_q);
			end
			OP_SCAN_WR: begin
				idx_q  <= idx_next;
				left_q <= left_q - CNT_W'(1);
			end
			OP_OUT: begin
				window_total_q <= total_q[OUT_W-1:0];
			end
			default: begin
				now_q <= now_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q     <= '0;
			started_q   <= 1'b0;
			total_q     <= '0;
			cur_q       <= '0;
			clr_q       <= '0;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// load a new total, else hold while the receiver stalls
			out_valid_q <= (cmd == OP_OUT) || (out_valid_q && out_stall);
			case (cmd)
				OP_LOAD: begin
					if (!started_q) begin
						start_q   <= now_seconds;
						started_q <= 1'b1;
					end
				end
				OP_CFG_CLR: begin
					total_q <= '0;
					cur_q   <= '0;
					clr_q   <= '0;
				end
				OP_CLR_STEP: begin
					clr_q <= sts.clr_last ? '0 : clr_q + IDX_W'(1);
				end
				OP_DIV_INIT: begin
					div_cnt_q <= '0;
				end
				OP_DIV_STEP: begin
					div_cnt_q <= div_cnt_q + DIVCNT_W'(1);
				end
				OP_FULL: begin
					total_q <= '0;
					cur_q   <= '0;
					clr_q   <= '0;
					start_q <= now_q;
				end
				OP_SCAN_INIT: begin
					start_q <= now_q;
				end
				OP_SCAN_WR: begin
					// the last bucket passed becomes the current one
					total_q <= total_q - TOT_W'(rd_q);
					cur_q   <= idx_q;
				end
				OP_ADD_WR: begin
					total_q <= total_q - TOT_W'(rd_q) + TOT_W'(add_next);
				end
				default: begin
					clr_q <= clr_q;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign window_total = window_total_q;

endmodule

`default_nettype wire

@@ hw/rtl/bucketed_window_activity_total_unit.sv @@
// Sliding-window activity total over a ring of MAX_BUCKETS time buckets. Each request
// carries the time in seconds and the active seconds to add, and returns one window total.
// Requests are handled one at a time. A request that moves the ring first runs the
// 23-step divider and its decision, then reads and clears each bucket passed (single-port
// bucket memory, read then clear), or clears the whole ring; a positive count of active
// seconds is then added to the current bucket. After reset, and after a bucket_count
// write taken while idle, a clearing pass runs through the whole bucket memory with
// in_stall high. The next request is taken while a result waits on out_stall.
// Registers: bucket_length at byte address 0, bucket_count at byte address 4.
`default_nettype none

module bucketed_window_activity_total_unit
	import bwat_pkg::*;
#(
	parameter int MAX_BUCKETS = 64
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     psel,
	input  wire                     penable,
	input  wire                     pwrite,
	input  wire  [APB_AW-1:0]       paddr,
	input  wire  [APB_DW-1:0]       pwdata,
	output logic [APB_DW-1:0]       prdata,
	output logic                    pready,
	input  wire                     in_valid,
	output logic                    in_stall,
	input  wire  [NOW_W-1:0]        now_seconds,
	input  wire  signed [ACT_W-1:0] active_seconds,
	output logic                    out_valid,
	input  wire                     out_stall,
	output logic [OUT_W-1:0]        window_total
);

	logic [LEN_W-1:0]     bucket_length_q;
	logic [CNT_REG_W-1:0] bucket_count_q;
	logic                 cfg_wr;
	logic                 cfg_clear;
	op_t                  cmd;
	sts_t                 sts;

	assign pready    = 1'b1;
	assign cfg_wr    = psel && penable && pwrite && pready;
	assign cfg_clear = cfg_wr && (paddr[2] == REG_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_length_q <= LEN_RESET;
			bucket_count_q  <= COUNT_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_LENGTH: bucket_length_q <= pwdata[LEN_W-1:0];
				REG_COUNT:  bucket_count_q  <= pwdata[CNT_REG_W-1:0];
				default:    bucket_length_q <= bucket_length_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_LENGTH: prdata = APB_DW'(bucket_length_q);
			REG_COUNT:  prdata = APB_DW'(bucket_count_q);
			default:    prdata = '0;
		endcase
	end

	bwat_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.cfg_clear (cfg_clear),
		.sts       (sts),
		.cmd       (cmd),
		.in_stall  (in_stall)
	);

	bwat_datapath #(
		.MAX_BUCKETS (MAX_BUCKETS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.bucket_length  (bucket_length_q),
		.bucket_count   (bucket_count_q),
		.now_seconds    (now_seconds),
		.active_seconds (active_seconds),
		.out_stall      (out_stall),
		.out_valid      (out_valid),
		.window_total   (window_total)
	);

endmodule

`default_nettype wire

@@ hw/rtl/bwat_checker.sv @@
`default_nettype none

module bwat_checker
	import bwat_pkg::*;
(
	input wire                     clk,
	input wire                     arst_n,
	input wire                     psel,
	input wire                     penable,
	input wire                     pwrite,
	input wire  [APB_AW-1:0]       paddr,
	input wire                     pready,
	input wire                     in_valid,
	input wire                     in_stall,
	input wire                     out_valid,
	input wire                     out_stall,
	input wire  [OUT_W-1:0]        window_total
);

	// one request in flight at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request accepted while previous one still in work");

	// a bucket_count write is checked to stall the input for the clearing pass
	a_count_clears: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready && (paddr[2] == REG_COUNT) |=> in_stall)
		else $error("input not stalled during clearing pass");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(window_total))
		else $error("stalled result dropped or changed");

endmodule

bind bucketed_window_activity_total_unit bwat_checker u_bwat_checker (.*);

`default_nettype wire
